>>> design/lpd_pkg.sv
// Shared constants and types for the length-prefixed packet deframer.
package lpd_pkg;

  // Default length of the size header in bytes.
  localparam int unsigned LPD_SIZE_BYTES = 4;

  // Request codes on the input channel.
  localparam logic LPD_REQ_BYTE  = 1'b0;
  localparam logic LPD_REQ_CLOSE = 1'b1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       packet_end;
    logic       protocol_error;
  } lpd_result_t;

endpackage

>>> design/lpd_if.sv
// Valid/ready channel interfaces for the deframer input and result streams.
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface lpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic       packet_end;
  logic       protocol_error;

  modport source (
    output valid, output payload_byte, output has_byte, output packet_end,
    output protocol_error, input ready
  );
  modport sink (
    input valid, input payload_byte, input has_byte, input packet_end,
    input protocol_error, output ready
  );
endinterface

>>> design/lpd_out_stage.sv
// Result register that holds one word until the downstream side takes it.
module lpd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lpd_pkg::lpd_result_t res_i,
  output logic                ready_o,
  lpd_out_if.source           out_o
);
  import lpd_pkg::*;

  logic        valid_q;
  logic        valid_d;
  lpd_result_t res_q;

  // The register can be loaded when it is empty or being emptied this cycle.
  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.payload_byte   = res_q.payload_byte;
  assign out_o.has_byte       = res_q.has_byte;
  assign out_o.packet_end     = res_q.packet_end;
  assign out_o.protocol_error = res_q.protocol_error;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!valid_q || out_o.ready))
    else $error("result register loaded while a word is still held");
`endif

endmodule

>>> design/length_prefixed_packet_deframer.sv
// Top level of the length-prefixed packet deframer.
// A payload, empty-packet or error result is offered in the cycle after its input word.
// Throughput: one input word per cycle; a held result stalls all input until it is taken.
// Per word: a header-byte insert, a size compare and subtract, a count decrement or a close.
// Reset clears the header collection, the payload count and the sticky error flag at once.
module length_prefixed_packet_deframer #(
  parameter int unsigned SIZE_BYTES = lpd_pkg::LPD_SIZE_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpd_in_if.sink    in_i,
  lpd_out_if.source out_o
);
  import lpd_pkg::*;

  localparam int unsigned HdrW  = 8 * (SIZE_BYTES - 1);
  localparam int unsigned SizeW = 8 * SIZE_BYTES;
  localparam int unsigned LeftW = SizeW - 1;
  localparam int unsigned CntW  = $clog2(SIZE_BYTES);

  logic [HdrW-1:0]  hdr_q, hdr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             in_payload_q, in_payload_d;
  logic [LeftW-1:0] left_q, left_d;
  logic             failed_q, failed_d;

  logic             in_fire;
  logic             stage_ready;
  logic             res_valid;
  lpd_result_t      res;
  logic [SizeW-1:0] size;

  assign in_i.ready = stage_ready;
  assign in_fire    = in_i.valid && stage_ready;
  assign size       = {in_i.rx_byte, hdr_q};

  always_comb begin
    hdr_d        = hdr_q;
    cnt_d        = cnt_q;
    in_payload_d = in_payload_q;
    left_d       = left_q;
    failed_d     = failed_q;
    res_valid    = 1'b0;
    res          = '0;
    if (in_fire && !failed_q) begin
      if (in_i.req_type == LPD_REQ_CLOSE) begin
        hdr_d        = '0;
        cnt_d        = '0;
        in_payload_d = 1'b0;
        left_d       = '0;
      end else if (in_payload_q) begin
        left_d           = left_q - LeftW'(1);
        res_valid        = 1'b1;
        res.payload_byte = in_i.rx_byte;
        res.has_byte     = 1'b1;
        if (left_q == LeftW'(1)) begin
          in_payload_d   = 1'b0;
          res.packet_end = 1'b1;
        end
      end else if (cnt_q != CntW'(SIZE_BYTES - 1)) begin
        hdr_d[{cnt_q, 3'b000} +: 8] = in_i.rx_byte;
        cnt_d = cnt_q + CntW'(1);
      end else begin
        // Last header byte: its top bit is the sign of the size.
        hdr_d = '0;
        cnt_d = '0;
        if (in_i.rx_byte[7] || size < SizeW'(SIZE_BYTES)) begin
          failed_d           = 1'b1;
          res_valid          = 1'b1;
          res.protocol_error = 1'b1;
        end else if (size == SizeW'(SIZE_BYTES)) begin
          res_valid      = 1'b1;
          res.packet_end = 1'b1;
        end else begin
          left_d       = size[LeftW-1:0] - LeftW'(SIZE_BYTES);
          in_payload_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q        <= '0;
      cnt_q        <= '0;
      in_payload_q <= 1'b0;
      left_q       <= '0;
      failed_q     <= 1'b0;
    end else begin
      hdr_q        <= hdr_d;
      cnt_q        <= cnt_d;
      in_payload_q <= in_payload_d;
      left_q       <= left_d;
      failed_q     <= failed_d;
    end
  end

  lpd_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .res_i   (res),
    .ready_o (stage_ready),
    .out_o   (out_o)
  );

`ifndef ASSERT_OFF
  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |=> failed_q)
    else $error("protocol error flag cleared without reset");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q == (left_q != '0))
    else $error("payload flag and remaining count disagree");

  a_error_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.protocol_error) |=> failed_q)
    else $error("error word given without setting the sticky flag");

  a_header_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (cnt_q == '0 && hdr_q == '0))
    else $error("header bytes held while a payload is in flight");
`endif

endmodule

>>> dv/length_prefixed_packet_deframer_test.sv
// Self-checking testbench for the length-prefixed packet deframer.
module length_prefixed_packet_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpd_pkg::*;

  localparam int unsigned HDR = LPD_SIZE_BYTES;

  // Where the expectation for a word comes from: the predictor, or typed in the table.
  typedef enum logic [2:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_EMPTY,
    CHK_LAST_BYTE,
    CHK_ERROR
  } check_kind_e;

  typedef struct packed {
    logic        req;
    logic [7:0]  data;
    check_kind_e kind;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  lpd_in_if  in_if ();
  lpd_out_if out_if ();

  length_prefixed_packet_deframer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state, cleared as after reset.
  logic [8*(HDR-1)-1:0] hdr_acc     = '0;
  int unsigned          hdr_cnt     = 0;
  bit                   in_body     = 1'b0;
  logic [8*HDR-2:0]     body_left   = '0;
  bit                   stream_dead = 1'b0;

  lpd_result_t pending_results[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned words_sent     = 0;
  int unsigned burst_left     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic bit deframe_word(input logic req, input logic [7:0] data,
                                      output lpd_result_t res);
    logic [8*HDR-1:0] size;
    res = '0;
    if (stream_dead) return 1'b0;
    if (req == LPD_REQ_CLOSE) begin
      hdr_acc   = '0;
      hdr_cnt   = 0;
      in_body   = 1'b0;
      body_left = '0;
      return 1'b0;
    end
    if (in_body) begin
      body_left        = body_left - 1'b1;
      res.payload_byte = data;
      res.has_byte     = 1'b1;
      if (body_left == '0) begin
        in_body        = 1'b0;
        res.packet_end = 1'b1;
      end
      return 1'b1;
    end
    if (hdr_cnt < HDR - 1) begin
      hdr_acc[8*hdr_cnt +: 8] = data;
      hdr_cnt++;
      return 1'b0;
    end
    // The last header byte carries the sign of the size.
    size    = {data, hdr_acc};
    hdr_acc = '0;
    hdr_cnt = 0;
    if (data[7] || size < HDR) begin
      stream_dead        = 1'b1;
      res.protocol_error = 1'b1;
      return 1'b1;
    end
    if (size == HDR) begin
      res.packet_end = 1'b1;
      return 1'b1;
    end
    body_left = (8*HDR-1)'(size - HDR);
    in_body   = 1'b1;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic add_row(input logic req, input logic [7:0] data, input check_kind_e kind);
    directed_rows.push_back('{req: req, data: data, kind: kind});
  endtask

  // Offers one word in bursts with random gaps, then books its expected result on acceptance.
  task automatic send_word(input logic req, input logic [7:0] data, input check_kind_e kind);
    lpd_result_t res;
    bit          got;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid    <= 1'b1;
    in_if.req_type <= req;
    in_if.rx_byte  <= data;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
    got = deframe_word(req, data, res);
    case (kind)
      CHK_MODEL:     if (got) pending_results.push_back(res);
      CHK_EMPTY:     pending_results.push_back(lpd_result_t'{8'h00, 1'b0, 1'b1, 1'b0});
      CHK_LAST_BYTE: pending_results.push_back(lpd_result_t'{data, 1'b1, 1'b1, 1'b0});
      CHK_ERROR:     pending_results.push_back(lpd_result_t'{8'h00, 1'b0, 1'b0, 1'b1});
      default: ;
    endcase
  endtask

  // A packet of the given size; a close replaces the word at position cut_at, if reached.
  task automatic send_packet(input logic [8*HDR-1:0] size, input int unsigned body_len,
                             input int cut_at);
    for (int i = 0; i < HDR + body_len; i++) begin
      if (i == cut_at) begin
        send_word(LPD_REQ_CLOSE, 8'($urandom), CHK_MODEL);
        return;
      end
      if (i < HDR) send_word(LPD_REQ_BYTE, size[8*i +: 8], CHK_MODEL);
      else send_word(LPD_REQ_BYTE, 8'($urandom_range(255)), CHK_MODEL);
    end
  endtask

  // Receiver: ready follows a changing pattern, with one long hold-off to fill the block.
  initial begin
    int unsigned phase_left;
    int unsigned rx_mode;
    int unsigned hold_left;
    bit          hold_done;
    phase_left = 0;
    rx_mode    = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 250) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_if.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(16, 96);
          rx_mode    = $urandom_range(3);
        end
        phase_left--;
        case (rx_mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(1));
          2:       out_if.ready <= (phase_left % 4 == 0);
          default: out_if.ready <= ($urandom_range(4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    lpd_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h has %b end %b err %b",
                        out_if.payload_byte, out_if.has_byte, out_if.packet_end,
                        out_if.protocol_error));
      end else begin
        want = pending_results.pop_front();
        if (out_if.payload_byte !== want.payload_byte)
          report_mismatch($sformatf("payload_byte %02h, want %02h",
                          out_if.payload_byte, want.payload_byte));
        if (out_if.has_byte !== want.has_byte)
          report_mismatch($sformatf("has_byte %b, want %b", out_if.has_byte, want.has_byte));
        if (out_if.packet_end !== want.packet_end)
          report_mismatch($sformatf("packet_end %b, want %b",
                          out_if.packet_end, want.packet_end));
        if (out_if.protocol_error !== want.protocol_error)
          report_mismatch($sformatf("protocol_error %b, want %b",
                          out_if.protocol_error, want.protocol_error));
      end
    end
  end

  initial begin
    logic [8*HDR-1:0] size;
    int unsigned      body_len;
    int unsigned      pick;
    int               cut_at;

    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.req_type <= LPD_REQ_BYTE;
    in_if.rx_byte  <= 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty packet.
    add_row(LPD_REQ_BYTE, 8'h04, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h00, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h00, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h00, CHK_EMPTY);
    // One payload word.
    add_row(LPD_REQ_BYTE, 8'h05, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h00, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h00, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h00, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'hAA, CHK_LAST_BYTE);
    // Two payload words at the data extremes.
    add_row(LPD_REQ_BYTE, 8'h06, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h00, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h00, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h00, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h00, CHK_MODEL);
    add_row(LPD_REQ_BYTE, 8'hFF, CHK_MODEL);
    // Largest positive size, cut short by a close after one word.
    add_row(LPD_REQ_BYTE, 8'hFF, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'hFF, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'hFF, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h7F, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h12, CHK_MODEL);
    add_row(LPD_REQ_CLOSE, 8'h00, CHK_NONE);
    // Close in the middle of a header.
    add_row(LPD_REQ_BYTE, 8'h09, CHK_NONE);
    add_row(LPD_REQ_BYTE, 8'h00, CHK_NONE);
    add_row(LPD_REQ_CLOSE, 8'hFF, CHK_NONE);

    foreach (directed_rows[i])
      send_word(directed_rows[i].req, directed_rows[i].data, directed_rows[i].kind);

    // Mostly complete packets with small bodies; some are cut by a close or are huge.
    while (words_sent < 1450) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_word(LPD_REQ_CLOSE, 8'($urandom), CHK_MODEL);
      end else if (pick < 9) begin
        size              = $urandom;
        size[8*HDR-1]     = 1'b0;
        size[8*HDR-2 -: 2] = 2'b01;
        body_len          = $urandom_range(1, 11);
        send_packet(size, body_len, HDR + body_len - 1);
      end else begin
        pick = $urandom_range(99);
        if (pick < 15) body_len = 0;
        else if (pick < 85) body_len = $urandom_range(1, 12);
        else if (pick < 97) body_len = $urandom_range(13, 64);
        else body_len = $urandom_range(65, 300);
        size   = HDR + body_len;
        cut_at = ($urandom_range(19) == 0) ? $urandom_range(0, HDR + body_len - 1) : -1;
        send_packet(size, body_len, cut_at);
      end
    end

    // Finally a bad size, either negative or shorter than the header; the stream then dies.
    send_word(LPD_REQ_CLOSE, 8'h00, CHK_NONE);
    if ($urandom_range(1) == 1) begin
      size          = $urandom;
      size[8*HDR-1] = 1'b1;
    end else begin
      size = $urandom_range(HDR - 1);
    end
    for (int i = 0; i < HDR; i++)
      send_word(LPD_REQ_BYTE, size[8*i +: 8], (i == HDR - 1) ? CHK_ERROR : CHK_NONE);
    repeat (30)
      send_word(($urandom_range(1) == 1) ? LPD_REQ_CLOSE : LPD_REQ_BYTE, 8'($urandom),
                CHK_MODEL);
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
